// ===== src/mcdt_pkg.sv =====
package mcdt_pkg;

   localparam int POINT_COUNT = 4;
   localparam int COORD_W     = 13;
   localparam int CENTER_W    = 12;
   localparam int MEAN_W      = 17;
   localparam int SEEN_W      = 3;
   localparam int SQ_W        = 2 * CENTER_W + 1;
   localparam int RAD_W       = 2 * MEAN_W;
   localparam int REM_W       = MEAN_W + 1;
   localparam int TRIAL_W     = MEAN_W + 3;
   localparam int SQRT_STEPS  = MEAN_W;
   localparam int STEP_W      = 5;
   localparam int SUM_W       = MEAN_W + 2;
   localparam int DIV3_W      = 20;
   localparam int DIV3_SHIFT  = 21;
   localparam logic [DIV3_W-1:0] DIV3_MUL = 20'd699051;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic CSR_CENTER_X = 1'b0;
   localparam logic CSR_CENTER_Y = 1'b1;
   localparam logic [CENTER_W-1:0] CENTER_X_RESET = 12'd320;
   localparam logic [CENTER_W-1:0] CENTER_Y_RESET = 12'd240;

   typedef struct packed {
      logic load;
      logic square;
      logic step;
   } lane_ctrl_type;

   typedef struct packed {
      logic sum;
      logic divide;
      logic commit;
   } merge_ctrl_type;

endpackage

// ===== src/mcdt_req_if.sv =====
interface mcdt_req_if;
   import mcdt_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] point0_x;
   logic signed [COORD_W-1:0] point0_y;
   logic signed [COORD_W-1:0] point1_x;
   logic signed [COORD_W-1:0] point1_y;
   logic signed [COORD_W-1:0] point2_x;
   logic signed [COORD_W-1:0] point2_y;
   logic signed [COORD_W-1:0] point3_x;
   logic signed [COORD_W-1:0] point3_y;

   modport source (
      output valid, point0_x, point0_y, point1_x, point1_y,
             point2_x, point2_y, point3_x, point3_y,
      input  ready
   );
   modport sink (
      input  valid, point0_x, point0_y, point1_x, point1_y,
             point2_x, point2_y, point3_x, point3_y,
      output ready
   );
endinterface

// ===== src/mcdt_rsp_if.sv =====
interface mcdt_rsp_if;
   import mcdt_pkg::*;

   logic              valid;
   logic              ready;
   logic              moving_closer;
   logic [MEAN_W-1:0] mean_distance;
   logic [SEEN_W-1:0] points_seen;

   modport source (
      output valid, moving_closer, mean_distance, points_seen,
      input  ready
   );
   modport sink (
      input  valid, moving_closer, mean_distance, points_seen,
      output ready
   );
endinterface

// ===== src/marker_center_distance_trend_top.sv =====
// Marker center-distance trend: each request beat carries one frame with four
// marker points (a negative coordinate marks a point as unseen). Four lanes
// take the distance of each seen point to the center held in the csr
// registers, with four fraction bits, and a merge stage averages them and
// flags whether the mean dropped below the previous frame's mean. One frame
// is in flight at a time: the differences, the squares, the bit-serial square
// root in each lane, then sum, divide and result, which waits while the output
// register still holds an untaken result. The finished result sits in that
// output register, so the next frame is taken while it waits.
// A frame without any seen point returns zero and leaves the stored mean.
module marker_center_distance_trend_top (
   input  logic                            clock,
   input  logic                            reset,
   mcdt_req_if.sink                        req_ch,
   mcdt_rsp_if.source                      rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mcdt_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mcdt_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mcdt_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import mcdt_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SQUARE = 3'd1;
   localparam logic [2:0] ST_ROOT   = 3'd2;
   localparam logic [2:0] ST_SUM    = 3'd3;
   localparam logic [2:0] ST_DIVIDE = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [POINT_COUNT-1:0]  mask_ff, mask_in;
   logic [SEEN_W-1:0]       seen_ff, seen_in;
   logic [CENTER_W-1:0]     center_x_ff, center_y_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_closer_ff;
   logic [MEAN_W-1:0]       rsp_mean_ff;
   logic [SEEN_W-1:0]       rsp_seen_ff;

   logic                    accept;
   logic                    slot_free;
   logic                    csr_write;
   lane_ctrl_type           lane_ctrl;
   merge_ctrl_type          merge_ctrl;
   logic [POINT_COUNT-1:0][COORD_W-1:0] px, py;
   logic [POINT_COUNT-1:0][MEAN_W-1:0]  point_dist;
   logic [MEAN_W-1:0]       mean;
   logic                    closer;

   assign px = {req_ch.point3_x, req_ch.point2_x, req_ch.point1_x, req_ch.point0_x};
   assign py = {req_ch.point3_y, req_ch.point2_y, req_ch.point1_y, req_ch.point0_y};

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      seen_in = '0;
      for (int i = 0; i < POINT_COUNT; i++) begin
         mask_in[i] = !px[i][COORD_W-1] && !py[i][COORD_W-1];
         seen_in    = seen_in + SEEN_W'(mask_in[i]);
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            state_in = ST_ROOT;
            step_in  = '0;
         end
         ST_ROOT: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM:    state_in = ST_DIVIDE;
         ST_DIVIDE: state_in = ST_FINISH;
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      lane_ctrl.load    = accept;
      lane_ctrl.square  = (state_ff == ST_SQUARE);
      lane_ctrl.step    = (state_ff == ST_ROOT);
      merge_ctrl.sum    = (state_ff == ST_SUM);
      merge_ctrl.divide = (state_ff == ST_DIVIDE);
      merge_ctrl.commit = (state_ff == ST_FINISH) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mask_ff <= mask_in;
         seen_ff <= seen_in;
      end
   end

   for (genvar g = 0; g < POINT_COUNT; g++) begin : g_lane
      mcdt_lane u_lane (
         .clock      (clock),
         .ctrl       (lane_ctrl),
         .point_x    (px[g][CENTER_W-1:0]),
         .point_y    (py[g][CENTER_W-1:0]),
         .center_x   (center_x_ff),
         .center_y   (center_y_ff),
         .point_dist (point_dist[g])
      );
   end

   mcdt_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (merge_ctrl),
      .mask       (mask_ff),
      .seen       (seen_ff),
      .point_dist (point_dist),
      .mean       (mean),
      .closer     (closer)
   );

   // output register: hold the result until the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (merge_ctrl.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (merge_ctrl.commit) begin
         rsp_closer_ff <= closer;
         rsp_mean_ff   <= mean;
         rsp_seen_ff   <= seen_ff;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.moving_closer = rsp_closer_ff;
   assign rsp_ch.mean_distance = rsp_mean_ff;
   assign rsp_ch.points_seen   = rsp_seen_ff;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= CENTER_X_RESET;
         center_y_ff <= CENTER_Y_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            CSR_CENTER_X: center_x_ff <= csr_pwdata[CENTER_W-1:0];
            CSR_CENTER_Y: center_y_ff <= csr_pwdata[CENTER_W-1:0];
            default:      center_x_ff <= center_x_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_CENTER_X: csr_prdata = CSR_DATA_W'(center_x_ff);
         CSR_CENTER_Y: csr_prdata = CSR_DATA_W'(center_y_ff);
         default:      csr_prdata = '0;
      endcase
   end
endmodule

// ===== src/mcdt_lane.sv =====
module mcdt_lane (
   input  logic                             clock,
   input  mcdt_pkg::lane_ctrl_type          ctrl,
   input  logic [mcdt_pkg::CENTER_W-1:0]    point_x,
   input  logic [mcdt_pkg::CENTER_W-1:0]    point_y,
   input  logic [mcdt_pkg::CENTER_W-1:0]    center_x,
   input  logic [mcdt_pkg::CENTER_W-1:0]    center_y,
   output logic [mcdt_pkg::MEAN_W-1:0]      point_dist
);
   import mcdt_pkg::*;

   logic [CENTER_W-1:0] dx_ff, dx_in;
   logic [CENTER_W-1:0] dy_ff, dy_in;
   logic [RAD_W-1:0]    rad_ff, rad_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [MEAN_W-1:0]   root_ff, root_in;
   logic [SQ_W-1:0]     sq;
   logic [TRIAL_W-1:0]  rem_sh;
   logic [TRIAL_W-1:0]  trial;
   logic [TRIAL_W-1:0]  diff;

   always_comb begin
      dx_in = (point_x >= center_x) ? point_x - center_x : center_x - point_x;
      dy_in = (point_y >= center_y) ? point_y - center_y : center_y - point_y;
      sq    = SQ_W'(dx_ff * dx_ff) + SQ_W'(dy_ff * dy_ff);
      // bring down the next radicand pair
      rem_sh = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial  = {1'b0, root_ff, 2'b01};
      diff   = rem_sh - trial;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (ctrl.square) begin
         rad_in  = RAD_W'({sq, 8'h00});
         rem_in  = '0;
         root_in = '0;
      end else if (ctrl.step) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = diff[REM_W-1:0];
            root_in = {root_ff[MEAN_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[REM_W-1:0];
            root_in = {root_ff[MEAN_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign point_dist = root_ff;
endmodule

// ===== src/mcdt_merge.sv =====
module mcdt_merge (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  mcdt_pkg::merge_ctrl_type                             ctrl,
   input  logic [mcdt_pkg::POINT_COUNT-1:0]                     mask,
   input  logic [mcdt_pkg::SEEN_W-1:0]                          seen,
   input  logic [mcdt_pkg::POINT_COUNT-1:0][mcdt_pkg::MEAN_W-1:0] point_dist,
   output logic [mcdt_pkg::MEAN_W-1:0]                          mean,
   output logic                                                 closer
);
   import mcdt_pkg::*;

   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [MEAN_W-1:0] mean_ff, mean_in;
   logic [MEAN_W-1:0] prev_ff;
   logic [SUM_W+DIV3_W-1:0] prod;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < POINT_COUNT; i++) begin
         if (mask[i]) begin
            sum_in = sum_in + SUM_W'(point_dist[i]);
         end
      end
      prod = (SUM_W+DIV3_W)'(sum_ff) * (SUM_W+DIV3_W)'(DIV3_MUL);
      unique case (seen)
         3'd1:    mean_in = sum_ff[MEAN_W-1:0];
         3'd2:    mean_in = sum_ff[MEAN_W:1];
         3'd3:    mean_in = prod[DIV3_SHIFT +: MEAN_W];
         3'd4:    mean_in = sum_ff[MEAN_W+1:2];
         default: mean_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.sum) begin
         sum_ff <= sum_in;
      end
      if (ctrl.divide) begin
         mean_ff <= mean_in;
      end
   end

   // keep the last real mean across frames with no marker
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '1;
      end else if (ctrl.commit && seen != '0) begin
         prev_ff <= mean_ff;
      end
   end

   assign mean   = mean_ff;
   assign closer = (seen != '0) && (mean_ff < prev_ff);
endmodule

// ===== src/mcdt_check.sv =====
module mcdt_check (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          rsp_moving_closer,
   input  logic [mcdt_pkg::MEAN_W-1:0]   rsp_mean_distance,
   input  logic [mcdt_pkg::SEEN_W-1:0]   rsp_points_seen
);
   import mcdt_pkg::*;

   a_seen_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_points_seen <= SEEN_W'(POINT_COUNT))
      else $error("points_seen above point count");

   a_empty_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_points_seen == '0 |-> !rsp_moving_closer && rsp_mean_distance == '0)
      else $error("empty frame must report zero and not closer");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second frame taken while one is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mean_distance))
      else $error("stalled result beat changed");
endmodule

bind marker_center_distance_trend_top mcdt_check u_mcdt_check (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_moving_closer (rsp_ch.moving_closer),
   .rsp_mean_distance (rsp_ch.mean_distance),
   .rsp_points_seen   (rsp_ch.points_seen)
);
